// ===== rtl/fspe_pkg.sv =====
// shared constants and types for the fractional synth parameter encoder
package fspe_pkg;
  localparam int NUM_BANKS = 4;
  localparam int BYTES_PER_BANK = 8;
  localparam int DEPTH = NUM_BANKS * BYTES_PER_BANK;
  localparam int AW = $clog2(DEPTH);
  localparam logic [29:0] PLL_MAX_HZ = 30'd900000000;
  localparam logic [19:0] FRAC_DEN = 20'd1048575;
  localparam logic [31:0] P1_OFFSET = 32'd512;
  localparam logic [0:0] OP_COMPUTE = 1'b0;
  localparam logic [0:0] OP_UPDATE = 1'b1;
  localparam logic [0:0] CFG_XTAL = 1'b0;
  localparam logic [0:0] CFG_BASE = 1'b1;

  typedef struct packed {
    logic        start;
    logic [51:0] dividend;
    logic [29:0] divisor;
  } div_req_t;
endpackage

// ===== rtl/fractional_synth_param_encoder.sv =====
// top level: divider parameter sequencer, bank byte memory and register write output
// A compute item (op 0) runs three serial divisions on the shared one-bit-per-cycle
// divider, unless freq or the reference frequency is zero, when it is ignored. The
// step by the fixed fraction denominator is a shift-and-add reduction. Multiplies sit
// between the divisions; a pack step follows the reduction, then eight writes into the
// bank memory, one per cycle. An update item (op 1) reads the bank one byte per cycle
// and emits eight beats on consecutive cycles, strobe high on each, last on the eighth.
// busy is high from acceptance until the sequencer is back in idle; the last update
// beats still leave after busy falls. After reset a clearing pass zeroes every bank
// memory byte while busy stays high.
// Results cannot be held off: each beat appears for exactly one cycle.
module fractional_synth_param_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [27:0] freq,
  input  logic [1:0]  bank,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        strobe,
  output logic [7:0]  reg_addr,
  output logic [7:0]  reg_data,
  output logic        last
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_DIV2  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_DIV3  = 4'd6;
  localparam logic [3:0] S_FRAC  = 4'd7;
  localparam logic [3:0] S_PACK  = 4'd9;
  localparam logic [3:0] S_WRITE = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0]  state;
  logic [26:0] ref_hz;
  logic [7:0]  reg_base;
  logic [27:0] f;
  logic [1:0]  bk;
  logic [31:0] pll;
  logic [7:0]  mult;
  logic [19:0] num;
  logic [51:0] prod;
  logic [6:0]  q;
  logic [19:0] p2;
  logic [31:0] p1;
  logic [63:0] pack;
  logic [fspe_pkg::AW:0] idx;
  logic        div_wait;
  logic [26:0] frac_x;
  logic [20:0] frac_r;
  logic [20:0] frac_sub;
  logic        frac_fix;

  fspe_pkg::div_req_t req;
  logic        div_done;
  logic [51:0] div_q;
  logic [29:0] div_r;

  logic [7:0]  mem [fspe_pkg::DEPTH];
  logic        mem_we;
  logic [fspe_pkg::AW-1:0] mem_waddr;
  logic [fspe_pkg::AW-1:0] mem_raddr;
  logic [7:0]  mem_wdata;
  logic [7:0]  mem_rdata;
  logic        rd_v;
  logic [2:0]  rd_i;

  fspe_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .done(div_done),
    .quot(div_q),
    .rem (div_r)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    req = '0;
    mem_we = 1'b0;
    mem_waddr = idx[fspe_pkg::AW-1:0];
    mem_wdata = '0;
    mem_raddr = {bk, idx[2:0]};
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (start && op == fspe_pkg::OP_COMPUTE && freq != '0 && ref_hz != '0) begin
          req.start = 1'b1;
          req.dividend = {22'd0, fspe_pkg::PLL_MAX_HZ};
          req.divisor = {2'b0, freq};
        end
      end
      S_MUL1: begin
        req.start = 1'b1;
        req.dividend = {20'd0, pll};
        req.divisor = {3'b0, ref_hz};
      end
      S_MUL2: begin
        req.start = 1'b1;
        req.dividend = prod;
        req.divisor = {3'b0, ref_hz};
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_waddr = {bk, idx[2:0]};
        mem_wdata = pack[63:56];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      ref_hz <= 27'd25000000;
      reg_base <= 8'd26;
      strobe <= 1'b0;
      rd_v <= 1'b0;
      div_wait <= 1'b0;
    end else begin
      strobe <= rd_v;
      rd_v <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fspe_pkg::CFG_XTAL: ref_hz <= cfg_data[26:0];
          fspe_pkg::CFG_BASE: reg_base <= cfg_data[7:0];
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == (fspe_pkg::AW+1)'(fspe_pkg::DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          idx <= '0;
          if (start) begin
            f <= freq;
            bk <= bank;
            if (op == fspe_pkg::OP_UPDATE) state <= S_EMIT;
            else if (freq != '0 && ref_hz != '0) state <= S_DIV1;
          end
        end
        S_DIV1: if (div_done) begin
          pll <= 32'({div_q[29:1], 1'b0} * f);
          state <= S_MUL1;
        end
        S_MUL1: state <= S_DIV2;
        S_DIV2: if (div_done) begin
          mult <= div_q[7:0];
          prod <= {2'b0, div_r, 20'd0} - {22'd0, div_r};
          state <= S_MUL2;
        end
        S_MUL2: state <= S_DIV3;
        S_DIV3: if (div_done) begin
          num <= div_q[19:0];
          state <= S_FRAC;
        end
        S_FRAC: begin
          q <= frac_fix ? frac_x[26:20] + 7'd1 : frac_x[26:20];
          p2 <= frac_fix ? frac_sub[19:0] : frac_r[19:0];
          state <= S_PACK;
        end
        S_PACK: begin
          pack <= {fspe_pkg::FRAC_DEN[15:8], fspe_pkg::FRAC_DEN[7:0],
                   6'd0, p1[17:16], p1[15:8], p1[7:0],
                   fspe_pkg::FRAC_DEN[19:16], p2[19:16], p2[15:8], p2[7:0]};
          idx <= '0;
          state <= S_WRITE;
        end
        S_WRITE: begin
          pack <= {pack[55:0], 8'd0};
          idx <= idx + 1'b1;
          if (idx[2:0] == 3'd7) state <= S_IDLE;
        end
        S_EMIT: begin
          rd_v <= 1'b1;
          rd_i <= idx[2:0];
          idx <= idx + 1'b1;
          if (idx[2:0] == 3'd7) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      div_wait <= req.start;
    end
  end

  // 128*num over 2^20-1: high part plus low part, one correction
  assign frac_x = {num, 7'd0};
  assign frac_r = {1'b0, frac_x[19:0]} + {14'd0, frac_x[26:20]};
  assign frac_sub = frac_r - {1'b0, fspe_pkg::FRAC_DEN};
  assign frac_fix = (frac_r >= {1'b0, fspe_pkg::FRAC_DEN});

  assign p1 = {17'd0, mult, 7'd0} + {25'd0, q} - fspe_pkg::P1_OFFSET;

  always_ff @(posedge clk) begin
    reg_addr <= reg_base + {5'd0, rd_i};
    reg_data <= mem_rdata;
    last <= (rd_i == 3'd7);
  end

  a_strobe_not_idle_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !strobe || state == S_WRITE) else $error("write during emit");
  a_last_strobe: assert property (@(posedge clk) disable iff (rst)
    last && strobe |=> !strobe) else $error("beat after last");
  a_div_once: assert property (@(posedge clk) disable iff (rst)
    div_wait |-> !req.start) else $error("divider restarted");
endmodule

// ===== rtl/fspe_divider.sv =====
// restoring divider, one quotient bit per cycle, 52-bit dividend by 30-bit divisor
module fspe_divider (
  input  logic               clk,
  input  logic               rst,
  input  fspe_pkg::div_req_t req,
  output logic               done,
  output logic [51:0]        quot,
  output logic [29:0]        rem
);
  logic [51:0] q;
  logic [30:0] r;
  logic [29:0] d;
  logic [5:0]  cnt;
  logic        run;
  logic [30:0] trial;
  logic [31:0] sub;

  assign trial = {r[29:0], q[51]};
  assign sub = {1'b0, trial} - {2'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= 6'd52;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q <= req.dividend;
      r <= '0;
      d <= req.divisor;
    end else if (run) begin
      if (!sub[31]) begin
        r <= sub[30:0];
        q <= {q[50:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[50:0], 1'b0};
      end
    end
  end

  assign quot = q;
  assign rem = r[29:0];
endmodule

// ===== verif/fractional_synth_param_encoder_tb.sv =====
// self-checking testbench for the fractional synth parameter encoder
`timescale 1ns / 100ps

module fractional_synth_param_encoder_tb;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } reg_write_t;

  typedef struct {
    logic [0:0]  op;
    logic [27:0] freq;
    logic [1:0]  bank;
    bit          zero_known;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        op = 1'b0;
  logic [27:0] freq = '0;
  logic [1:0]  bank = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        strobe;
  logic [7:0]  reg_addr;
  logic [7:0]  reg_data;
  logic        last;

  logic [26:0] model_xtal;
  logic [7:0]  model_base;
  logic [7:0]  model_bytes [fspe_pkg::DEPTH];
  reg_write_t  pending_writes [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          writes_seen = 0;

  fractional_synth_param_encoder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .freq(freq),
    .bank(bank), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
    .reg_addr(reg_addr), .reg_data(reg_data), .last(last)
  );

  always #10 clk = ~clk;

  initial begin
    #20ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  // divider parameters for one bank
  task automatic store_divider(input logic [27:0] f, input logic [1:0] b);
    logic [31:0] dv, pll, mult, rem, num, q, p1, p2, p3;
    logic [63:0] wide;
    int base;
    if (f == 0 || model_xtal == 0 || b >= fspe_pkg::NUM_BANKS) return;
    dv = 32'd900000000 / {4'd0, f};
    dv[0] = 1'b0;
    pll = dv * {4'd0, f};
    mult = (pll / {5'd0, model_xtal}) & 32'hFF;
    rem = pll % {5'd0, model_xtal};
    wide = {32'd0, rem} * 64'd1048575 / {37'd0, model_xtal};
    num = wide[31:0];
    q = (32'd128 * num) / 32'd1048575;
    p1 = 32'd128 * mult + q - 32'd512;
    p2 = (32'd128 * num) % 32'd1048575;
    p3 = 32'd1048575;
    base = b * fspe_pkg::BYTES_PER_BANK;
    model_bytes[base]     = p3[15:8];
    model_bytes[base + 1] = p3[7:0];
    model_bytes[base + 2] = {6'd0, p1[17:16]};
    model_bytes[base + 3] = p1[15:8];
    model_bytes[base + 4] = p1[7:0];
    model_bytes[base + 5] = {p3[19:16], p2[19:16]};
    model_bytes[base + 6] = p2[15:8];
    model_bytes[base + 7] = p2[7:0];
  endtask

  task automatic issue(input logic [0:0] o, input logic [27:0] f, input logic [1:0] b,
                       input bit zero_known);
    reg_write_t w;
    start <= 1'b1;
    op <= o;
    freq <= f;
    bank <= b;
    do @(posedge clk); while (busy);
    items_sent++;
    if (o == fspe_pkg::OP_COMPUTE) begin
      store_divider(f, b);
    end else if (b < fspe_pkg::NUM_BANKS) begin
      for (int i = 0; i < fspe_pkg::BYTES_PER_BANK; i++) begin
        w.addr = model_base + 8'(i);
        w.data = zero_known ? 8'h00 : model_bytes[b * fspe_pkg::BYTES_PER_BANK + i];
        w.last = (i == fspe_pkg::BYTES_PER_BANK - 1);
        pending_writes.push_back(w);
      end
    end
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    repeat ($urandom_range(1, 20)) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (260) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == fspe_pkg::CFG_XTAL) model_xtal = val[26:0];
    else model_base = val[7:0];
  endtask

  function automatic logic [27:0] random_freq();
    case ($urandom_range(0, 4))
      0: return 28'($urandom);
      1: return 28'($urandom_range(1, 225000000));
      2: return 28'($urandom_range(1, 2000));
      3: return 28'($urandom_range(200000000, 268435455));
      default: return 28'($urandom_range(1000000, 30000000));
    endcase
  endfunction

  always @(posedge clk) begin
    reg_write_t want;
    if (!rst && strobe) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat addr=%0h data=%0h last=%0b", reg_addr, reg_data, last);
      end else begin
        want = pending_writes.pop_front();
        if (reg_addr !== want.addr || reg_data !== want.data || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr=%0h data=%0h last=%0b, got %0h %0h %0b",
                     want.addr, want.data, want.last, reg_addr, reg_data, last);
        end
      end
    end
  end

  initial begin
    stim_row_t table_rows [] = '{
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd0, 1'b1},
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd3, 1'b1},
      '{fspe_pkg::OP_COMPUTE, 28'd1, 2'd0, 1'b0},
      '{fspe_pkg::OP_COMPUTE, 28'd225000000, 2'd1, 1'b0},
      '{fspe_pkg::OP_COMPUTE, 28'hFFFFFFF, 2'd2, 1'b0},
      '{fspe_pkg::OP_COMPUTE, 28'd10000000, 2'd3, 1'b0},
      '{fspe_pkg::OP_UPDATE, 28'hFFFFFFF, 2'd0, 1'b0},
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd1, 1'b0},
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd2, 1'b0},
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd3, 1'b0},
      '{fspe_pkg::OP_COMPUTE, 28'd0, 2'd1, 1'b0},
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd1, 1'b0},
      '{fspe_pkg::OP_COMPUTE, 28'd7000000, 2'd2, 1'b0},
      '{fspe_pkg::OP_COMPUTE, 28'd150000001, 2'd0, 1'b0},
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd2, 1'b0},
      '{fspe_pkg::OP_UPDATE, 28'd0, 2'd0, 1'b0}
    };
    logic [31:0] phase_xtal [5] = '{32'd25000000, 32'h07FFFFFF, 32'd0, 32'd1000000,
                                    32'd100000000};
    logic [31:0] phase_base [5] = '{32'd26, 32'd255, 32'd0, 32'd128, 32'hFFFFFF1A};

    model_xtal = 27'd25000000;
    model_base = 8'd26;
    foreach (model_bytes[i]) model_bytes[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      issue(table_rows[i].op, table_rows[i].freq, table_rows[i].bank,
            table_rows[i].zero_known);
      if ($urandom_range(0, 2) == 0) pause_sender();
    end

    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(fspe_pkg::CFG_XTAL, phase_xtal[p]);
      write_reg(fspe_pkg::CFG_BASE, phase_base[p]);
      cfg_valid <= 1'b0;
      @(posedge clk);
      repeat (10) begin
        int burst = $urandom_range(1, 12);
        repeat (burst) begin
          if ($urandom_range(0, 9) < 6)
            issue(fspe_pkg::OP_COMPUTE, random_freq(), 2'($urandom), 1'b0);
          else
            issue(fspe_pkg::OP_UPDATE, 28'($urandom), 2'($urandom), 1'b0);
        end
        if ($urandom_range(0, 3) != 0) pause_sender();
      end
      issue(fspe_pkg::OP_COMPUTE, 28'hFFFFFFF, 2'd3, 1'b0);
      issue(fspe_pkg::OP_UPDATE, 28'd0, 2'd3, 1'b0);
    end

    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    mismatches += pending_writes.size();
    $display("%0d items driven over 5 register settings, %0d register write beats checked",
             items_sent, writes_seen);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
